// ----- src/bplc_pkg.sv -----
// Shared types and constants for the button press-length classifier.
// No dependencies.
package bplc_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int TICK_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERY_LONG = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLARITY  = 2'd3;

    localparam logic [TICK_W-1:0] DEBOUNCE_RESET  = 16'd50;
    localparam logic [TICK_W-1:0] LONG_RESET      = 16'd500;
    localparam logic [TICK_W-1:0] VERY_LONG_RESET = 16'd3000;

    localparam logic [1:0] KIND_SHORT = 2'd0;
    localparam logic [1:0] KIND_LONG  = 2'd1;
    localparam logic [1:0] KIND_VLONG = 2'd2;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_SHORT    = 3'd2,
        PH_LONG     = 3'd3,
        PH_VLONG    = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] debounce_ticks;
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] very_long_ticks;
        logic              pressed_polarity;
    } cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TICK_W-1:0] remaining;
        logic              prev_level;
    } state_t;

    // Packed to match the result tdata layout, lowest bit last.
    typedef struct packed {
        phase_t     phase_now;
        logic       hold_pulse;
        logic [1:0] press_kind;
        logic       press_valid;
    } result_t;

endpackage

// ----- src/button_press_length_classifier_top.sv -----
// Top level of the debounced button press-length classifier.
// Depends on bplc_pkg and bplc_step.
//
//   channel  | dir | tdata fields (low bit up)
//   ---------+-----+---------------------------------------------------------
//   s_       | in  | button_level[0]
//   m_       | out | press_valid[0] press_kind[2:1] hold_pulse[3] phase_now[6:4]
//   cfg_     | in  | cfg_index selects register, cfg_wdata[15:0] value
//
// One sample per cycle unless the result stalls; each request yields one result in
// the result register, loaded together with the phase machine and tick counter.
// A new sample is taken whenever the result register is empty or being drained.
// aresetn is synchronous, active low: phase idle, counter zero, config to defaults.
module button_press_length_classifier_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // button_level
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // press_valid, press_kind,
                                                          // hold_pulse, phase_now
    input  logic                               cfg_we,
    input  logic [bplc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bplc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import bplc_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    m_valid_reg;
    logic    accept;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

    bplc_step u_step (
        .state_cur (state_reg),
        .cfg       (cfg_reg),
        .level     (s_tdata[0]),
        .state_nxt (state_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= DEBOUNCE_RESET;
            cfg_reg.long_ticks       <= LONG_RESET;
            cfg_reg.very_long_ticks  <= VERY_LONG_RESET;
            cfg_reg.pressed_polarity <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE:  cfg_reg.debounce_ticks   <= cfg_wdata;
                REG_LONG:      cfg_reg.long_ticks       <= cfg_wdata;
                REG_VERY_LONG: cfg_reg.very_long_ticks  <= cfg_wdata;
                REG_POLARITY:  cfg_reg.pressed_polarity <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= PH_IDLE;
            state_reg.remaining  <= '0;
            state_reg.prev_level <= 1'b1;
            m_valid_reg          <= 1'b0;
        end else begin
            if (accept) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- src/bplc_step.sv -----
// Next-state and result logic for one button sample.
// Depends on bplc_pkg.
module bplc_step (
    input  bplc_pkg::state_t  state_cur,
    input  bplc_pkg::cfg_t    cfg,
    input  logic              level,
    output bplc_pkg::state_t  state_nxt,
    output bplc_pkg::result_t result
);
    import bplc_pkg::*;

    logic              pressed;
    logic              was_pressed;
    logic              expired;
    logic [TICK_W-1:0] rem_dec;

    assign pressed     = (level == cfg.pressed_polarity);
    assign was_pressed = (state_cur.prev_level == cfg.pressed_polarity);
    assign expired     = (state_cur.remaining <= TICK_W'(1));
    assign rem_dec     = state_cur.remaining - TICK_W'(1);

    always_comb begin
        state_nxt.phase      = state_cur.phase;
        state_nxt.remaining  = state_cur.remaining;
        state_nxt.prev_level = level;
        result.press_valid   = 1'b0;
        result.press_kind    = KIND_SHORT;
        result.hold_pulse    = 1'b0;

        case (state_cur.phase)
            PH_IDLE: begin
                if (pressed && !was_pressed) begin
                    state_nxt.phase     = PH_DEBOUNCE;
                    state_nxt.remaining = cfg.debounce_ticks;
                end
            end
            PH_DEBOUNCE: begin
                if (expired) begin
                    if (pressed) begin
                        state_nxt.phase     = PH_SHORT;
                        state_nxt.remaining = cfg.long_ticks;
                    end else begin
                        state_nxt.phase     = PH_IDLE;
                        state_nxt.remaining = '0;
                    end
                end else begin
                    state_nxt.remaining = rem_dec;
                end
            end
            PH_SHORT, PH_LONG: begin
                if (!pressed) begin
                    result.press_valid  = 1'b1;
                    result.press_kind   = (state_cur.phase == PH_SHORT) ? KIND_SHORT
                                                                        : KIND_LONG;
                    state_nxt.phase     = PH_IDLE;
                    state_nxt.remaining = '0;
                end else if (expired) begin
                    result.hold_pulse = 1'b1;
                    if (state_cur.phase == PH_SHORT) begin
                        state_nxt.phase     = PH_LONG;
                        state_nxt.remaining = cfg.very_long_ticks;
                    end else begin
                        state_nxt.phase     = PH_VLONG;
                        state_nxt.remaining = '0;
                    end
                end else begin
                    state_nxt.remaining = rem_dec;
                end
            end
            PH_VLONG: begin
                state_nxt.remaining = '0;
                if (!pressed) begin
                    result.press_valid = 1'b1;
                    result.press_kind  = KIND_VLONG;
                    state_nxt.phase    = PH_IDLE;
                end
            end
            default: begin
                state_nxt.phase     = PH_IDLE;
                state_nxt.remaining = '0;
            end
        endcase

        result.phase_now = state_nxt.phase;
    end

endmodule

// ----- src/bplc_checker.sv -----
// Port-level checks for the button press-length classifier, with bind.
// Depends on bplc_pkg and button_press_length_classifier_top.
module bplc_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);
    import bplc_pkg::*;

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_press_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[6:4] == PH_IDLE && !m_tdata[3])
        else $error("press report without return to idle");

    a_pulse_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[6:4] == PH_LONG || m_tdata[6:4] == PH_VLONG)
        else $error("hold pulse outside long phases");

    a_kind_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[2:1] == KIND_SHORT && !m_tdata[7])
        else $error("press kind set without press");

endmodule

bind button_press_length_classifier_top bplc_checker u_bplc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/press_class_checker.sv -----
// Checker for the button press-length classifier: watches the sample, result and
// register-write ports, predicts each result and compares it field by field.
// Depends on bplc_pkg.
module press_class_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // button_level
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,    // press_valid, press_kind,
                                                        // hold_pulse, phase_now
    input  logic                            cfg_we,
    input  logic [bplc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bplc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                              fail_count,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import bplc_pkg::*;

    logic [TICK_W-1:0] debounce_set;
    logic [TICK_W-1:0] long_set;
    logic [TICK_W-1:0] very_long_set;
    logic              polarity_set;

    phase_t            cur_phase;
    logic [TICK_W-1:0] ticks_left;
    logic              last_level;

    result_t press_results_q[$];

    task automatic flag_mismatch(input string msg);
        if (fail_count < 50) begin
            $display("%0t mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic logic count_down();
        if (ticks_left <= 16'd1) begin
            ticks_left = '0;
            return 1'b1;
        end
        ticks_left = ticks_left - 16'd1;
        return 1'b0;
    endfunction

    function automatic result_t classify_tick(input logic level);
        result_t r;
        logic    pressed;
        logic    was_pressed;
        r           = '0;
        pressed     = (level == polarity_set);
        was_pressed = (last_level == polarity_set);
        case (cur_phase)
            PH_IDLE: begin
                if (pressed && !was_pressed) begin
                    cur_phase  = PH_DEBOUNCE;
                    ticks_left = debounce_set;
                end
            end
            PH_DEBOUNCE: begin
                if (count_down()) begin
                    if (pressed) begin
                        cur_phase  = PH_SHORT;
                        ticks_left = long_set;
                    end else begin
                        cur_phase = PH_IDLE;
                    end
                end
            end
            PH_SHORT, PH_LONG: begin
                if (!pressed) begin
                    r.press_valid = 1'b1;
                    r.press_kind  = (cur_phase == PH_SHORT) ? KIND_SHORT : KIND_LONG;
                    cur_phase     = PH_IDLE;
                    ticks_left    = '0;
                end else if (count_down()) begin
                    r.hold_pulse = 1'b1;
                    if (cur_phase == PH_SHORT) begin
                        cur_phase  = PH_LONG;
                        ticks_left = very_long_set;
                    end else begin
                        cur_phase  = PH_VLONG;
                        ticks_left = '0;
                    end
                end
            end
            PH_VLONG: begin
                ticks_left = '0;
                if (!pressed) begin
                    r.press_valid = 1'b1;
                    r.press_kind  = KIND_VLONG;
                    cur_phase     = PH_IDLE;
                end
            end
            default: begin
                cur_phase  = PH_IDLE;
                ticks_left = '0;
            end
        endcase
        last_level  = level;
        r.phase_now = cur_phase;
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        result_t got;
        if (!aresetn) begin
            debounce_set  = DEBOUNCE_RESET;
            long_set      = LONG_RESET;
            very_long_set = VERY_LONG_RESET;
            polarity_set  = 1'b0;
            cur_phase     = PH_IDLE;
            ticks_left    = '0;
            last_level    = 1'b1;
            fail_count    = 0;
            press_results_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[6:0]);
                if (press_results_q.size() == 0) begin
                    flag_mismatch($sformatf("result 0x%02h with no request pending", m_tdata));
                end else begin
                    want = press_results_q.pop_front();
                    if (got.press_valid !== want.press_valid)
                        flag_mismatch($sformatf("press_valid got %0d want %0d",
                                                got.press_valid, want.press_valid));
                    if (got.press_kind !== want.press_kind)
                        flag_mismatch($sformatf("press_kind got %0d want %0d",
                                                got.press_kind, want.press_kind));
                    if (got.hold_pulse !== want.hold_pulse)
                        flag_mismatch($sformatf("hold_pulse got %0d want %0d",
                                                got.hold_pulse, want.hold_pulse));
                    if (got.phase_now !== want.phase_now)
                        flag_mismatch($sformatf("phase_now got %0d want %0d",
                                                got.phase_now, want.phase_now));
                end
                if (m_tdata[7] !== 1'b0)
                    flag_mismatch("padding bit of result set");
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEBOUNCE:  debounce_set  = cfg_wdata;
                    REG_LONG:      long_set      = cfg_wdata;
                    REG_VERY_LONG: very_long_set = cfg_wdata;
                    REG_POLARITY:  polarity_set  = cfg_wdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                press_results_q.push_back(classify_tick(s_tdata[0]));
            end
        end
        outstanding <= press_results_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the classifier bench: clock, reset, register setup, button sample
// stimulus and random back-pressure; the verdict comes from press_class_checker.
// Depends on bplc_pkg, button_press_length_classifier_top and press_class_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bplc_pkg::*;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;    // button_level
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [7:0]            m_tdata;           // press_valid, press_kind,
                                              // hold_pulse, phase_now
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int fail_count;
    int outstanding;

    int gap_pct   = 0;
    int stall_pct = 0;
    int samples_sent = 0;

    logic [TICK_W-1:0] debounce_now  = DEBOUNCE_RESET;
    logic [TICK_W-1:0] long_now      = LONG_RESET;
    logic [TICK_W-1:0] very_long_now = VERY_LONG_RESET;
    logic              polarity_now  = 1'b0;

    button_press_length_classifier_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    press_class_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_level(input logic level);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, level};
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic hold_level(input logic level, input int n);
        repeat (n) send_level(level);
    endtask

    // hold off requests until every result has been taken
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic configure(input logic [TICK_W-1:0] deb, input logic [TICK_W-1:0] lng,
                             input logic [TICK_W-1:0] vlng, input logic pol);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_wdata <= deb;
        @(posedge aclk);
        cfg_index <= REG_LONG;
        cfg_wdata <= lng;
        @(posedge aclk);
        cfg_index <= REG_VERY_LONG;
        cfg_wdata <= vlng;
        @(posedge aclk);
        cfg_index <= REG_POLARITY;
        cfg_wdata <= {{(CFG_DATA_W-1){1'b0}}, pol};
        @(posedge aclk);
        cfg_we <= 1'b0;
        debounce_now  = deb;
        long_now      = lng;
        very_long_now = vlng;
        polarity_now  = pol;
    endtask

    // mostly clean presses of random length, some with bounce, some raw noise
    task automatic press_burst();
        int span;
        int hold;
        int bounce;
        span = int'(debounce_now) + int'(long_now) + int'(very_long_now) + 4;
        if (span > 40) span = 40;
        if ($urandom_range(99) < 15) begin
            repeat ($urandom_range(1, 6)) send_level(1'($urandom_range(1)));
        end else begin
            hold_level(!polarity_now, $urandom_range(1, 3));
            hold   = $urandom_range(1, span);
            bounce = ($urandom_range(99) < 30) ? int'(debounce_now) : 0;
            send_level(polarity_now);
            for (int i = 1; i < hold; i++) begin
                send_level((i <= bounce) ? 1'($urandom_range(1)) : polarity_now);
            end
            send_level(!polarity_now);
        end
    endtask

    task automatic run_bursts(input int n);
        int start;
        start = samples_sent;
        while (samples_sent - start < n) press_burst();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: 50-tick debounce, active low, a press that ends short
        hold_level(1'b1, 2);
        hold_level(1'b0, 56);
        hold_level(1'b1, 2);

        configure(16'd1, 16'd1, 16'd1, 1'b0);
        hold_level(1'b1, 2);
        send_level(1'b0);                       // released when debounce expires
        hold_level(1'b1, 2);
        hold_level(1'b0, 2);                    // short
        send_level(1'b1);
        hold_level(1'b0, 3);                    // release on the expiry tick
        send_level(1'b1);
        hold_level(1'b0, 5);                    // very long
        send_level(1'b1);
        hold_level(1'b0, 2);
        configure(16'd1, 16'd1, 16'd1, 1'b1);  // polarity flip mid-press
        send_level(1'b0);
        hold_level(1'b1, 2);
        send_level(1'b0);

        configure(16'd1, 16'd4, 16'd3, 1'b1);
        run_bursts(90);
        configure(16'd0, 16'd0, 16'd0, 1'b0);
        gap_pct = 86;
        run_bursts(90);
        configure(16'd3, 16'd6, 16'd5, 1'b1);
        gap_pct   = 0;
        stall_pct = 86;
        run_bursts(90);
        configure(16'd2, 16'd5, 16'd8, 1'b0);
        gap_pct   = 25;
        stall_pct = 25;
        run_bursts(90);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        gap_pct   = 0;
        stall_pct = 0;
        run_bursts(40);
        while (samples_sent < 550) begin
            configure(16'($urandom_range(6)), 16'($urandom_range(6)),
                      16'($urandom_range(6)), 1'($urandom_range(1)));
            case ($urandom_range(3))
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 86; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 86; end
                default: begin gap_pct = 25; stall_pct = 25; end
            endcase
            run_bursts(60);
        end

        drain();
        repeat (8) @(posedge aclk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
